### rtl/rsmrm_pkg.sv
// Shared types and codes for the reading store with remove-min and mean.
// Used by every module of the block except the RAM; depends on nothing.
`default_nettype none

package rsmrm_pkg;

	typedef enum logic [1:0] {
		MODE_APPEND = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_MEAN   = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_code_t;

	localparam int MEAN_BITS = 40;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [31:0] reading;
	} in_item_t;

	typedef struct packed {
		logic [1:0]                  status;
		logic signed [MEAN_BITS-1:0] mean_q8;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_MOVE,
		ST_DIV,
		ST_MEAN_OUT
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic         append;
		logic         emit;
		status_code_t emit_status;
		logic         emit_mean;
		logic         scan_init;
		logic         scan_issue;
		logic         read_last;
		logic         move;
		logic         div_init;
		logic         div_step;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic full;
		logic empty;
		logic scan_last;
		logic div_last;
	} dp_status_t;

endpackage

`default_nettype wire

### rtl/rsmrm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rsmrm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### rtl/rsmrm_ctrl.sv
// Controller state machine: decodes the operation and sequences the datapath.
// Depends on rsmrm_pkg.
`default_nettype none

module rsmrm_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [1:0]            mode,
	input  wire rsmrm_pkg::dp_status_t sts,
	output rsmrm_pkg::cmd_t            cmd,
	output logic                       busy
);

	rsmrm_pkg::state_t state_q, state_nx;
	logic              accept;

	assign accept = start && (state_q == rsmrm_pkg::ST_IDLE);
	assign busy   = (state_q != rsmrm_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsmrm_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			rsmrm_pkg::ST_IDLE: begin
				if (accept && mode == rsmrm_pkg::MODE_REMOVE && !sts.empty) begin
					state_nx = rsmrm_pkg::ST_SCAN;
				end else if (accept && mode == rsmrm_pkg::MODE_MEAN && !sts.empty) begin
					state_nx = rsmrm_pkg::ST_DIV;
				end
			end
			rsmrm_pkg::ST_SCAN: begin
				if (sts.scan_last) begin
					state_nx = rsmrm_pkg::ST_LAST;
				end
			end
			rsmrm_pkg::ST_LAST:     state_nx = rsmrm_pkg::ST_MOVE;
			rsmrm_pkg::ST_MOVE:     state_nx = rsmrm_pkg::ST_IDLE;
			rsmrm_pkg::ST_DIV: begin
				if (sts.div_last) begin
					state_nx = rsmrm_pkg::ST_MEAN_OUT;
				end
			end
			rsmrm_pkg::ST_MEAN_OUT: state_nx = rsmrm_pkg::ST_IDLE;
			default:                state_nx = rsmrm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd             = '0;
		cmd.emit_status = rsmrm_pkg::STAT_OK;
		unique case (state_q)
			rsmrm_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (mode)
						rsmrm_pkg::MODE_APPEND: begin
							cmd.emit = 1'b1;
							if (sts.full) begin
								cmd.emit_status = rsmrm_pkg::STAT_FULL;
							end else begin
								cmd.append = 1'b1;
							end
						end
						rsmrm_pkg::MODE_REMOVE: begin
							if (sts.empty) begin
								cmd.emit        = 1'b1;
								cmd.emit_status = rsmrm_pkg::STAT_EMPTY;
							end else begin
								cmd.scan_init = 1'b1;
							end
						end
						rsmrm_pkg::MODE_MEAN: begin
							if (sts.empty) begin
								cmd.emit        = 1'b1;
								cmd.emit_status = rsmrm_pkg::STAT_EMPTY;
							end else begin
								cmd.div_init = 1'b1;
							end
						end
						default: cmd.emit = 1'b1;
					endcase
				end
			end
			rsmrm_pkg::ST_SCAN: cmd.scan_issue = 1'b1;
			rsmrm_pkg::ST_LAST: cmd.read_last  = 1'b1;
			rsmrm_pkg::ST_MOVE: begin
				cmd.move = 1'b1;
				cmd.emit = 1'b1;
			end
			rsmrm_pkg::ST_DIV:  cmd.div_step = 1'b1;
			rsmrm_pkg::ST_MEAN_OUT: begin
				cmd.emit      = 1'b1;
				cmd.emit_mean = 1'b1;
			end
			default: ;
		endcase
	end

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_init || cmd.div_init) |-> !sts.empty)
		else $error("scan or division started on an empty store");
	a_last_to_move: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rsmrm_pkg::ST_LAST) |=> (state_q == rsmrm_pkg::ST_MOVE))
		else $error("last-entry fetch not followed by move");
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.append, cmd.scan_init, cmd.div_init, cmd.move}) <= 1)
		else $error("conflicting datapath commands");

endmodule

`default_nettype wire

### rtl/rsmrm_dp.sv
// Datapath: reading RAM, entry count, running sum, min scan and serial divider.
// Depends on rsmrm_pkg and rsmrm_ram.
`default_nettype none

module rsmrm_dp #(
	parameter int DEPTH      = 64,
	parameter int VALUE_BITS = 32,
	localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW  = $clog2(DEPTH + 1),
	localparam int SW  = VALUE_BITS + CW,
	localparam int QW  = SW + 8,
	localparam int DCW = $clog2(QW)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire rsmrm_pkg::cmd_t       cmd,
	input  wire rsmrm_pkg::in_item_t   request,
	output rsmrm_pkg::dp_status_t      sts,
	output logic                       done,
	output rsmrm_pkg::out_item_t       result
);

	logic [CW-1:0]         count_q;
	logic signed [SW-1:0]  sum_q;

	logic [AW-1:0]         idx_q;
	logic [AW-1:0]         rd_idx_s1;
	logic                  rd_vld_s1;
	logic [AW-1:0]         best_q;
	logic [VALUE_BITS-1:0] min_q;

	logic [QW-1:0]         dq_q;
	logic [CW-1:0]         rem_q;
	logic [DCW-1:0]        dcnt_q;
	logic                  neg_q;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [VALUE_BITS-1:0] ram_wdata;
	logic [AW-1:0]         ram_raddr;
	logic [VALUE_BITS-1:0] ram_rdata;

	logic [CW-1:0]         count_m1;
	logic [CW:0]           trial;
	logic                  ge;
	logic [SW-1:0]         sum_mag;
	logic signed [QW:0]    quot_s;

	logic                  done_q;
	rsmrm_pkg::out_item_t  result_q;

	assign count_m1      = count_q - CW'(1);
	assign sts.full      = (count_q == CW'(DEPTH));
	assign sts.empty     = (count_q == '0);
	assign sts.scan_last = (CW'(idx_q) == count_m1);
	assign sts.div_last  = (dcnt_q == DCW'(QW - 1));

	// Append writes at the tail; move fills the removed slot with the tail entry.
	assign ram_we    = cmd.append || cmd.move;
	assign ram_waddr = cmd.move ? best_q : AW'(count_q);
	assign ram_wdata = cmd.move ? ram_rdata : request.reading[VALUE_BITS-1:0];
	assign ram_raddr = cmd.read_last ? AW'(count_m1) : idx_q;

	rsmrm_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
		end else if (cmd.append) begin
			count_q <= count_q + CW'(1);
			sum_q   <= sum_q + SW'($signed(request.reading[VALUE_BITS-1:0]));
		end else if (cmd.move) begin
			count_q <= count_m1;
			sum_q   <= sum_q - SW'($signed(min_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_issue;
		end
	end

	// Min scan: issue one read a cycle, compare in the cycle after the read.
	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			idx_q <= '0;
		end else if (cmd.scan_issue) begin
			idx_q <= idx_q + AW'(1);
		end
		rd_idx_s1 <= idx_q;
		if (rd_vld_s1) begin
			if (rd_idx_s1 == '0 || $signed(ram_rdata) < $signed(min_q)) begin
				min_q  <= ram_rdata;
				best_q <= rd_idx_s1;
			end
		end
	end

	// Restoring divider on the magnitude, one quotient bit per cycle.
	assign sum_mag = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
	assign trial   = {rem_q, dq_q[QW-1]};
	assign ge      = (trial >= {1'b0, count_q});

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			dq_q   <= {sum_mag, 8'd0};
			rem_q  <= '0;
			dcnt_q <= '0;
			neg_q  <= sum_q[SW-1];
		end else if (cmd.div_step) begin
			dq_q   <= {dq_q[QW-2:0], ge};
			rem_q  <= ge ? CW'(trial - {1'b0, count_q}) : CW'(trial);
			dcnt_q <= dcnt_q + DCW'(1);
		end
	end

	assign quot_s = neg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.status  <= cmd.emit_status;
			result_q.mean_q8 <= cmd.emit_mean ? rsmrm_pkg::MEAN_BITS'(quot_s) : '0;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count beyond depth");
	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |-> !sts.full)
		else $error("append into a full store");
	a_move_dec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.move |=> count_q == CW'($past(count_q) - CW'(1)))
		else $error("remove did not drop the count by one");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> !sts.empty)
		else $error("division by a zero count");

endmodule

`default_nettype wire

### rtl/reading_store_min_remove_mean.sv
// Top level of the reading store with remove-min and mean.
// Depends on rsmrm_pkg, rsmrm_ctrl, rsmrm_dp (and rsmrm_ram through it).
//
// Usage:
//   Request channel: drive request and raise start; the transfer happens at
//   the clock edge where start is high and busy is low. mode picks append,
//   remove smallest or mean; reading is used by append only (low VALUE_BITS
//   bits, sign-extended).
//   Result channel: done pulses high for exactly one cycle with result; the
//   receiver cannot stall, so sample result whenever done is high.
// Steps of each operation after the accepting edge:
//   append, empty-store cases and the undefined mode: result is registered
//     at that edge and busy stays low, so a new request can follow every cycle.
//   remove smallest: one RAM read per entry sets the scan, then one read of
//     the tail entry and one write to close the gap, which also registers result.
//   mean: the restoring divider retires one quotient bit per cycle of a QW-bit
//     quotient, QW = VALUE_BITS + clog2(DEPTH+1) + 8 (47 at the defaults).
// Reset: asynchronous, clears the entry count, the running sum and control;
//   the reading RAM is not cleared, since only entries below the count are read.
//   No clearing pass: the block takes requests right after reset.
`default_nettype none

module reading_store_min_remove_mean #(
	parameter int DEPTH      = 64,
	parameter int VALUE_BITS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire rsmrm_pkg::in_item_t  request,
	output logic                      done,
	output rsmrm_pkg::out_item_t      result
);

	rsmrm_pkg::cmd_t       cmd;
	rsmrm_pkg::dp_status_t sts;

	// Sequence each operation: decode on transfer, then step the datapath.
	rsmrm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (request.mode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Hold the store, the count and the sum; run the scan and the divider.
	rsmrm_dp #(
		.DEPTH      (DEPTH),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.request (request),
		.sts     (sts),
		.done    (done),
		.result  (result)
	);

endmodule

`default_nettype wire

### tb/rsmrm_checker.sv
// Result checker for the reading store: watches both channels, predicts each
// result from its own copy of the store and compares. Depends on rsmrm_pkg.
`timescale 1ns / 1ps

module rsmrm_checker #(
	parameter int DEPTH      = 64,
	parameter int VALUE_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  rsmrm_pkg::in_item_t             request,
	input  logic                            done,
	input  rsmrm_pkg::out_item_t            result,
	output int                              errors,
	output int                              pending,
	output int                              checked,
	output int                              full_drops,
	output int                              empty_replies
);

	logic signed [31:0]   stored_readings[$];
	longint               reading_total;
	rsmrm_pkg::out_item_t awaited_results[$];
	rsmrm_pkg::out_item_t due;
	int                   err_cnt;
	int                   chk_cnt;
	int                   full_cnt;
	int                   empty_cnt;

	// Add a reading at the tail of the store copy.
	function automatic void store_reading(logic signed [31:0] v);
		stored_readings.insert(stored_readings.size(), v);
	endfunction

	// Queue a predicted result behind the ones still outstanding.
	function automatic void queue_result(rsmrm_pkg::out_item_t r);
		awaited_results.insert(awaited_results.size(), r);
	endfunction

	// Apply one request to the store copy and return the result it must give.
	function automatic rsmrm_pkg::out_item_t apply_request(rsmrm_pkg::in_item_t item);
		rsmrm_pkg::out_item_t outcome;
		logic signed [31:0]   value;
		longint               quotient;
		int                   lowest;
		outcome = '0;
		unique case (rsmrm_pkg::mode_t'(item.mode))
			rsmrm_pkg::MODE_APPEND: begin
				if (stored_readings.size() >= DEPTH) begin
					outcome.status = rsmrm_pkg::STAT_FULL;
				end else begin
					value = $signed(item.reading << (32 - VALUE_BITS)) >>> (32 - VALUE_BITS);
					store_reading(value);
					reading_total += value;
				end
			end
			rsmrm_pkg::MODE_REMOVE: begin
				if (stored_readings.size() == 0) begin
					outcome.status = rsmrm_pkg::STAT_EMPTY;
				end else begin
					// earliest entry wins among equal minimums
					lowest = 0;
					for (int i = 1; i < stored_readings.size(); i++)
						if (stored_readings[i] < stored_readings[lowest])
							lowest = i;
					reading_total -= stored_readings[lowest];
					stored_readings.delete(lowest);
				end
			end
			rsmrm_pkg::MODE_MEAN: begin
				if (stored_readings.size() == 0) begin
					outcome.status = rsmrm_pkg::STAT_EMPTY;
				end else begin
					quotient = (reading_total * 256) / longint'(stored_readings.size());
					outcome.mean_q8 = quotient[rsmrm_pkg::MEAN_BITS-1:0];
				end
			end
			default: ;
		endcase
		return outcome;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_readings.delete();
			awaited_results.delete();
			reading_total = 0;
			err_cnt = 0;
			chk_cnt = 0;
			full_cnt = 0;
			empty_cnt = 0;
		end else begin
			if (done) begin
				if (awaited_results.size() == 0) begin
					$error("result with nothing outstanding: status %0d mean_q8 %0d",
						result.status, result.mean_q8);
					err_cnt++;
				end else begin
					due = awaited_results.pop_front();
					if (result.status !== due.status) begin
						$error("status: expected %0d, actual %0d", due.status, result.status);
						err_cnt++;
					end
					if (result.mean_q8 !== due.mean_q8) begin
						$error("mean_q8: expected %0d, actual %0d", due.mean_q8, result.mean_q8);
						err_cnt++;
					end
					chk_cnt++;
					if (due.status == rsmrm_pkg::STAT_FULL)
						full_cnt++;
					if (due.status == rsmrm_pkg::STAT_EMPTY)
						empty_cnt++;
				end
			end
			if (start && !busy)
				queue_result(apply_request(request));
		end
		errors        <= err_cnt;
		pending       <= awaited_results.size();
		checked       <= chk_cnt;
		full_drops    <= full_cnt;
		empty_replies <= empty_cnt;
	end

endmodule

### tb/tb_reading_store_min_remove_mean.sv
// Testbench top for the reading store with remove-min and mean: drives the
// request channel, hosts the checker beside the block and gives the verdict.
// Depends on rsmrm_pkg, rsmrm_checker and the block's RTL.
`timescale 1ns / 1ps

module tb_reading_store_min_remove_mean;

	localparam int DEPTH      = 64;
	localparam int VALUE_BITS = 32;
	// Slowest item is a remove on a full store plus the longest send gap;
	// allow many times that with nothing transferred.
	localparam int STALL_LIMIT = 1000;
	// Settle time after the last expected result: covers a remove on a full store.
	localparam int DRAIN_CYCLES = 70;
	localparam int ROUNDS = 3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	rsmrm_pkg::in_item_t  request = '0;
	logic                 done;
	rsmrm_pkg::out_item_t result;

	int errors;
	int pending;
	int checked;
	int full_drops;
	int empty_replies;

	int sent = 0;
	int level = 0;     // store occupancy as seen from the stimulus side
	int max_gap = 4;   // 0 gives back-to-back bursts
	int idle_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	reading_store_min_remove_mean #(
		.DEPTH     (DEPTH),
		.VALUE_BITS(VALUE_BITS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.request(request),
		.done   (done),
		.result (result)
	);

	rsmrm_checker #(
		.DEPTH     (DEPTH),
		.VALUE_BITS(VALUE_BITS)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.done         (done),
		.result       (result),
		.errors       (errors),
		.pending      (pending),
		.checked      (checked),
		.full_drops   (full_drops),
		.empty_replies(empty_replies)
	);

	// Watchdog: restart on every transfer in either direction, give up when
	// the block has gone quiet for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Mix of extremes, a narrow band around zero (to force equal minimums)
	// and full-range values.
	function automatic logic signed [31:0] pick_reading();
		unique case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'($urandom_range(0, 16)) - 32'd8;
			default: return $urandom;
		endcase
	endfunction

	// Hold off a random gap, present the request, then wait for the transfer.
	// Only the falling edge touches start and request.
	task automatic send(rsmrm_pkg::mode_t mode, logic signed [31:0] reading);
		int gap;
		gap = $urandom_range(0, max_gap);
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start   <= 1'b1;
		request <= '{mode: mode, reading: reading};
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sent++;
		// track occupancy so the fill and drain phases know when to turn
		if (mode == rsmrm_pkg::MODE_APPEND && level < DEPTH)
			level++;
		if (mode == rsmrm_pkg::MODE_REMOVE && level > 0)
			level--;
	endtask

	// Random content for any mode; ignored readings still toggle.
	task automatic send_random_mode(int append_pct, int remove_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < append_pct)
			send(rsmrm_pkg::MODE_APPEND, pick_reading());
		else if (roll < append_pct + remove_pct)
			send(rsmrm_pkg::MODE_REMOVE, $urandom);
		else if (roll < 97)
			send(rsmrm_pkg::MODE_MEAN, $urandom);
		else
			send(rsmrm_pkg::MODE_NONE, $urandom);
	endtask

	initial begin
		int extra;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: every operation on an empty store, the reading extremes,
		// duplicate minimums, truncation of a negative mean.
		send(rsmrm_pkg::MODE_MEAN, 32'sd0);
		send(rsmrm_pkg::MODE_REMOVE, 32'sd0);
		send(rsmrm_pkg::MODE_NONE, 32'sh5a5a5a5a);
		send(rsmrm_pkg::MODE_APPEND, 32'sh7fffffff);
		send(rsmrm_pkg::MODE_APPEND, 32'sh80000000);
		send(rsmrm_pkg::MODE_MEAN, 32'sd0);
		send(rsmrm_pkg::MODE_APPEND, 32'sd0);
		send(rsmrm_pkg::MODE_APPEND, -32'sd1);
		send(rsmrm_pkg::MODE_APPEND, 32'sd5);
		send(rsmrm_pkg::MODE_APPEND, -32'sd1);
		send(rsmrm_pkg::MODE_REMOVE, 32'sd0);  // takes the most negative reading
		send(rsmrm_pkg::MODE_REMOVE, 32'sd0);  // takes one of the two equal -1s
		send(rsmrm_pkg::MODE_MEAN, 32'sd0);
		send(rsmrm_pkg::MODE_NONE, 32'sh12345678);
		repeat (4) send(rsmrm_pkg::MODE_REMOVE, 32'sd0);
		send(rsmrm_pkg::MODE_REMOVE, 32'sd0);
		send(rsmrm_pkg::MODE_MEAN, 32'sd0);
		send(rsmrm_pkg::MODE_APPEND, -32'sd7);
		send(rsmrm_pkg::MODE_APPEND, 32'sd3);
		send(rsmrm_pkg::MODE_APPEND, 32'sd2);
		send(rsmrm_pkg::MODE_MEAN, 32'sd0);    // -512/3 truncates to -170

		// Random rounds: fill past full, mixed traffic, drain past empty,
		// mixed again. Some phases run without any send gaps.
		for (int r = 0; r < ROUNDS; r++) begin
			max_gap = (r == 1) ? 0 : 4;
			extra = 0;
			while (extra < 3) begin
				if (level == DEPTH)
					extra++;
				send_random_mode(90, 4);
			end
			send(rsmrm_pkg::MODE_MEAN, $urandom);
			max_gap = 4;
			repeat (30) send_random_mode(35, 30);
			max_gap = (r == 2) ? 0 : 4;
			extra = 0;
			while (extra < 2) begin
				if (level == 0)
					extra++;
				send_random_mode(4, 90);
			end
			send(rsmrm_pkg::MODE_MEAN, $urandom);
			max_gap = 4;
			repeat (30) send_random_mode(35, 30);
		end

		@(negedge clk);
		start <= 1'b0;

		// Let every outstanding result arrive, then give a stray strobe
		// time to show up.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests covering every mode; %0d results checked,", sent, checked);
		$display("%0d appends dropped on a full store, %0d empty-store replies.",
			full_drops, empty_replies);
		if (errors == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### filelist.f
rtl/rsmrm_pkg.sv
rtl/rsmrm_ram.sv
rtl/rsmrm_ctrl.sv
rtl/rsmrm_dp.sv
rtl/reading_store_min_remove_mean.sv
tb/rsmrm_checker.sv
tb/tb_reading_store_min_remove_mean.sv
